>>> rtl/ksb_pkg.sv
package ksb_pkg;

  localparam int KeyW     = 72;
  localparam int TexW     = 32;
  localparam int SlotOutW = 6;

  localparam logic [15:0] PassBias = 16'h8000;

  typedef struct packed {
    logic [15:0] pass_key;
    logic [31:0] tex;
    logic [23:0] color;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic shift;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_INSERT
  } state_t;

endpackage

>>> rtl/ksb_cell.sv
module ksb_cell #(
  parameter int SW  = 6,
  parameter int CW  = 7,
  parameter int IDX = 0
) (
  input  logic              clk,
  input  ksb_pkg::cmd_t     cmd,
  input  logic [CW-1:0]     count,
  input  ksb_pkg::entry_t   new_ent,
  input  logic [SW-1:0]     new_slot,
  input  logic              left_gt,
  input  ksb_pkg::entry_t   left_ent,
  input  logic [SW-1:0]     left_slot,
  input  ksb_pkg::entry_t   right_ent,
  input  logic [SW-1:0]     right_slot,
  input  logic [31:0]       right_atex,
  output logic              gt,
  output ksb_pkg::entry_t   ent,
  output logic [SW-1:0]     slot,
  output logic [31:0]       atex
);
  import ksb_pkg::*;

  entry_t            ent_r, ent_nxt;
  logic [SW-1:0]     slot_r, slot_nxt;
  logic [TexW-1:0]   atex_r, atex_nxt;
  logic [KeyW-1:0]   own_key;
  logic [KeyW-1:0]   new_key;
  logic              occ;
  logic              tail;

  assign own_key = ent_r;
  assign new_key = new_ent;
  assign occ     = count > CW'(IDX);
  assign tail    = count == CW'(IDX);
  assign gt      = occ && (own_key > new_key);

  always_comb begin
    ent_nxt  = ent_r;
    slot_nxt = slot_r;
    atex_nxt = atex_r;
    if (cmd.shift) begin
      ent_nxt  = right_ent;
      slot_nxt = right_slot;
      atex_nxt = right_atex;
    end else if (cmd.ins) begin
      if (left_gt) begin
        ent_nxt  = left_ent;
        slot_nxt = left_slot;
      end else if (gt || tail) begin
        ent_nxt  = new_ent;
        slot_nxt = new_slot;
      end
      if (tail) begin
        atex_nxt = new_ent.tex;
      end
    end
  end

  always_ff @(posedge clk) begin
    ent_r  <= ent_nxt;
    slot_r <= slot_nxt;
    atex_r <= atex_nxt;
  end

  assign ent  = ent_r;
  assign slot = slot_r;
  assign atex = atex_r;

endmodule

>>> rtl/ksb_ctrl.sv
module ksb_ctrl #(
  parameter int CAPACITY = 64,
  parameter int SW       = 6,
  parameter int CW       = 7
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_req_type,
  input  logic           out_stall,
  output logic           in_stall,
  output logic           out_valid,
  output ksb_pkg::cmd_t  cmd,
  output logic [CW-1:0]  count,
  output logic [SW-1:0]  emit_idx,
  output logic           sel_pend
);
  import ksb_pkg::*;

  state_t         state_r, state_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [SW-1:0]  idx_r, idx_nxt;
  logic           pend_r, pend_nxt;
  logic           in_acc;
  logic           out_acc;
  logic           full;
  logic           empty;
  logic           final_beat;

  assign full       = count_r == CW'(CAPACITY);
  assign empty      = count_r == '0;
  assign final_beat = count_r == CW'(1);
  assign in_acc     = in_valid && !in_stall;
  assign out_acc    = out_valid && !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_req_type ? !empty : full)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_acc && final_beat) begin
          state_nxt = pend_r ? ST_INSERT : ST_IDLE;
        end
      end
      ST_INSERT: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    sel_pend  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.ins  = in_valid && !in_req_type && !full;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        cmd.shift = !out_stall;
      end
      ST_INSERT: begin
        sel_pend = 1'b1;
        cmd.ins  = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    idx_nxt   = idx_r;
    pend_nxt  = pend_r;
    if (cmd.ins) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.shift) begin
      count_nxt = count_r - CW'(1);
    end
    if (out_acc) begin
      idx_nxt = final_beat ? '0 : idx_r + SW'(1);
    end
    if (state_r == ST_IDLE && in_acc && !in_req_type && full) begin
      pend_nxt = 1'b1;
    end else if (state_r == ST_INSERT) begin
      pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      idx_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      pend_r  <= pend_nxt;
    end
  end

  assign count    = count_r;
  assign emit_idx = idx_r;

endmodule

>>> rtl/keyed_sort_batcher.sv
// Keyed sort batcher: collects draw entries and emits their slots in key or arrival order.
// Input channel (in_valid/in_stall): a beat with in_req_type 0 adds an entry
// holding pass number, texture id and colour; in_req_type 1 flushes the store.
// An add goes into the ordered cell row as it is taken, so adds are taken one
// per cycle while in_stall is low; the row's broadcast compare sets this.
// The cycle after a non-empty flush has the first result beat on the output
// channel (out_valid/out_stall), then one result per cycle while the receiver
// does not stall. Order is pass (signed), texture (unsigned), colour, with ties
// in arrival order; with cfg_wdata written as 1 results come in arrival order.
// Each result flags the start of a texture run and the last beat of the flush.
// An add to a full store drains the whole store first, then inserts the new
// entry in the ST_INSERT state. While results drain, in_stall stays high.
// A stalled result holds its value; the cell row simply does not shift.
// Reset empties the store and clears the ordering register; there is no
// clearing pass and the block is ready as soon as reset is released.
module keyed_sort_batcher #(
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_req_type,
  input  logic signed [15:0]  in_pass_number,
  input  logic [31:0]         in_texture_id,
  input  logic [23:0]         in_rgb_color,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [5:0]          out_slot_index,
  output logic [31:0]         out_texture_out,
  output logic                out_new_run,
  output logic                out_last
);
  import ksb_pkg::*;

  localparam int SW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int SXW = (SW > SlotOutW) ? SW : SlotOutW;

  logic            keep_r;
  entry_t          pend_r;
  logic [31:0]     prev_tex_r;
  entry_t          in_ent;
  entry_t          new_ent;
  cmd_t            cmd;
  logic [CW-1:0]   count;
  logic [SW-1:0]   emit_idx;
  logic            sel_pend;
  logic [SW-1:0]   sel_slot;
  logic [SXW-1:0]  slot_ext;

  entry_t          c_ent  [CAPACITY];
  logic [SW-1:0]   c_slot [CAPACITY];
  logic [31:0]     c_atex [CAPACITY];
  logic            c_gt   [CAPACITY];

  assign in_ent.pass_key = $unsigned(in_pass_number) ^ PassBias;
  assign in_ent.tex      = in_texture_id;
  assign in_ent.color    = in_rgb_color;
  assign new_ent         = sel_pend ? pend_r : in_ent;

  ksb_ctrl #(
    .CAPACITY (CAPACITY),
    .SW       (SW),
    .CW       (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .out_stall   (out_stall),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .cmd         (cmd),
    .count       (count),
    .emit_idx    (emit_idx),
    .sel_pend    (sel_pend)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic          l_gt;
    entry_t        l_ent;
    logic [SW-1:0] l_slot;
    entry_t        r_ent;
    logic [SW-1:0] r_slot;
    logic [31:0]   r_atex;

    if (i == 0) begin : g_head
      assign l_gt   = 1'b0;
      assign l_ent  = '0;
      assign l_slot = '0;
    end else begin : g_mid
      assign l_gt   = c_gt[i-1];
      assign l_ent  = c_ent[i-1];
      assign l_slot = c_slot[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_ent  = c_ent[i];
      assign r_slot = c_slot[i];
      assign r_atex = c_atex[i];
    end else begin : g_body
      assign r_ent  = c_ent[i+1];
      assign r_slot = c_slot[i+1];
      assign r_atex = c_atex[i+1];
    end

    ksb_cell #(
      .SW  (SW),
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .count      (count),
      .new_ent    (new_ent),
      .new_slot   (count[SW-1:0]),
      .left_gt    (l_gt),
      .left_ent   (l_ent),
      .left_slot  (l_slot),
      .right_ent  (r_ent),
      .right_slot (r_slot),
      .right_atex (r_atex),
      .gt         (c_gt[i]),
      .ent        (c_ent[i]),
      .slot       (c_slot[i]),
      .atex       (c_atex[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_r <= 1'b0;
    end else if (cfg_we) begin
      keep_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      pend_r <= in_ent;
    end
    if (out_valid && !out_stall) begin
      prev_tex_r <= out_texture_out;
    end
  end

  assign sel_slot        = keep_r ? emit_idx : c_slot[0];
  assign slot_ext        = SXW'(sel_slot);
  assign out_slot_index  = slot_ext[SlotOutW-1:0];
  assign out_texture_out = keep_r ? c_atex[0] : c_ent[0].tex;
  assign out_new_run     = (emit_idx == '0) || (out_texture_out != prev_tex_r);
  assign out_last        = count == CW'(1);

endmodule

>>> rtl/ksb_checker.sv
module ksb_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [5:0]         out_slot_index,
  input logic [31:0]        out_texture_out,
  input logic               out_last
);

  a_no_add_while_draining: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while results are draining");

  a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last) |=> out_valid)
    else $error("flush ended before its last beat");

  a_burst_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last) |=> !out_valid)
    else $error("result beat after the last beat of a flush");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_slot_index)
                                  && $stable(out_texture_out) && $stable(out_last)))
    else $error("stalled result changed");

endmodule

bind keyed_sort_batcher ksb_checker u_ksb_checker (.*);

>>> tb/keyed_sort_batcher_tb.sv
module keyed_sort_batcher_tb;
  import ksb_pkg::*;

  localparam int Depth = 64;
  localparam logic ReqAdd = 1'b0;
  localparam logic ReqFlush = 1'b1;
  localparam bit SortedOrder = 1'b0;
  localparam bit ArrivalOrder = 1'b1;

  typedef struct {
    logic [SlotOutW-1:0] slot;
    logic [TexW-1:0]     tex;
    logic                new_run;
    logic                last;
  } draw_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic               cfg_wdata = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_req_type = 1'b0;
  logic signed [15:0] in_pass_number = '0;
  logic [31:0]        in_texture_id = '0;
  logic [23:0]        in_rgb_color = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [5:0]         out_slot_index;
  logic [31:0]        out_texture_out;
  logic               out_new_run;
  logic               out_last;

  keyed_sort_batcher i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_pass_number (in_pass_number),
    .in_texture_id  (in_texture_id),
    .in_rgb_color   (in_rgb_color),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_slot_index (out_slot_index),
    .out_texture_out(out_texture_out),
    .out_new_run    (out_new_run),
    .out_last       (out_last)
  );

  always #4 clk = ~clk;

  // Shadow copy of the draw store and its ordered slot list.
  logic signed [15:0] pass_store [Depth];
  logic [31:0]        tex_store [Depth];
  logic [23:0]        colour_store [Depth];
  int                 order_list [Depth];
  int                 entry_total = 0;
  bit                 keep_order = 1'b0;
  draw_result_t       pending_results [$];
  int                 fail_count = 0;

  int burst_left = 0;
  bit steady_send = 1'b0;
  int stall_mode = 0;
  int stall_tick = 0;

  function automatic bit sorts_after(int a, int b);
    if (pass_store[a] != pass_store[b]) return pass_store[a] > pass_store[b];
    if (tex_store[a] != tex_store[b]) return tex_store[a] > tex_store[b];
    return colour_store[a] > colour_store[b];
  endfunction

  function automatic void emit_store();
    draw_result_t r;
    logic [31:0] prev_tex;
    int slot;
    prev_tex = '0;
    for (int i = 0; i < entry_total; i++) begin
      slot = keep_order ? i : order_list[i];
      r.slot = slot[SlotOutW-1:0];
      r.tex = tex_store[slot];
      r.new_run = (i == 0) || (tex_store[slot] != prev_tex);
      r.last = (i == entry_total - 1);
      prev_tex = tex_store[slot];
      pending_results.push_back(r);
    end
    entry_total = 0;
  endfunction

  function automatic void predict_beat(logic req, logic signed [15:0] pass_no,
                                       logic [31:0] tex, logic [23:0] colour);
    int pos;
    if (req == ReqFlush) begin
      emit_store();
      return;
    end
    if (entry_total >= Depth) emit_store();
    pass_store[entry_total] = pass_no;
    tex_store[entry_total] = tex;
    colour_store[entry_total] = colour;
    pos = entry_total;
    while (pos > 0 && sorts_after(order_list[pos-1], entry_total)) begin
      order_list[pos] = order_list[pos-1];
      pos--;
    end
    order_list[pos] = entry_total;
    entry_total++;
  endfunction

  always @(posedge clk) begin
    draw_result_t want;
    if (rst_n) begin
      if (cfg_we) keep_order = cfg_wdata;
      if (in_valid && !in_stall) begin
        predict_beat(in_req_type, in_pass_number, in_texture_id, in_rgb_color);
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result beat with nothing expected: slot_index %0d", out_slot_index);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_slot_index !== want.slot) begin
            $error("slot_index: expected %0d, actual %0d", want.slot, out_slot_index);
            fail_count++;
          end
          if (out_texture_out !== want.tex) begin
            $error("texture_out: expected %h, actual %h", want.tex, out_texture_out);
            fail_count++;
          end
          if (out_new_run !== want.new_run) begin
            $error("new_run: expected %0d, actual %0d", want.new_run, out_new_run);
            fail_count++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, out_last);
            fail_count++;
          end
        end
      end
    end
  end

  // The receiver switches between stall habits, picked at random.
  always @(posedge clk) begin
    if (stall_tick % 48 == 0) stall_mode = $urandom_range(0, 3);
    stall_tick++;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= (stall_tick % 6 < 2);
      default: out_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  task automatic send_item(logic req, logic signed [15:0] pass_no, logic [31:0] tex,
                           logic [23:0] colour);
    if (burst_left == 0 && !steady_send) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_pass_number <= pass_no;
    in_texture_id <= tex;
    in_rgb_color <= colour;
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic add_entry(logic signed [15:0] pass_no, logic [31:0] tex, logic [23:0] colour);
    send_item(ReqAdd, pass_no, tex, colour);
  endtask

  task automatic flush_store();
    send_item(ReqFlush, 16'($urandom), $urandom, 24'($urandom));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    wait (pending_results.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_order(bit arrival);
    cfg_we <= 1'b1;
    cfg_wdata <= arrival;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [15:0] rand_pass();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 4) - 2);
      1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_tex();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      3: return 32'h789A_BCDE;
      default: return $urandom_range(0, 3);
    endcase
  endfunction

  function automatic logic [23:0] rand_colour();
    if ($urandom_range(0, 1)) return 24'($urandom);
    return 24'($urandom_range(0, 2));
  endfunction

  task automatic test_sorted_keys();
    set_order(SortedOrder);
    flush_store();
    add_entry(16'h7FFF, 32'h0000_0000, 24'h000000);
    add_entry(16'h8000, 32'hFFFF_FFFF, 24'hFFFFFF);
    add_entry(16'h0000, 32'h8000_0000, 24'h000001);
    add_entry(16'h0000, 32'h7FFF_FFFF, 24'hFFFFFF);
    add_entry(16'hFFFF, 32'h7FFF_FFFF, 24'h000000);
    add_entry(16'h0000, 32'h8000_0000, 24'h000000);
    add_entry(16'h0000, 32'h8000_0000, 24'h000001);
    add_entry(16'h8000, 32'hFFFF_FFFF, 24'hFFFFFF);
    add_entry(16'h0001, 32'h789A_BCDE, 24'h123456);
    add_entry(16'h0001, 32'h789A_BCDE, 24'h123456);
    flush_store();
    flush_store();
    wait_idle();
  endtask

  task automatic test_arrival_order();
    set_order(ArrivalOrder);
    add_entry(16'h0005, 32'h0000_0002, 24'hFFFFFF);
    add_entry(16'h0004, 32'h0000_0002, 24'h000000);
    add_entry(16'h8000, 32'h0000_0001, 24'h000000);
    add_entry(16'h7FFF, 32'h0000_0001, 24'h800000);
    add_entry(16'h0000, 32'hFFFF_FFFF, 24'h000000);
    add_entry(16'h0000, 32'hFFFF_FFFF, 24'h000000);
    flush_store();
    wait_idle();
  endtask

  // Filling the store and adding once more forces a flush ahead of the add.
  task automatic test_full_store();
    for (int v = 0; v < 2; v++) begin
      set_order(v[0]);
      repeat (Depth + 1) add_entry(rand_pass(), rand_tex(), rand_colour());
      add_entry(rand_pass(), rand_tex(), rand_colour());
      flush_store();
      wait_idle();
    end
  endtask

  task automatic test_random();
    int flush_odds;
    for (int phase = 0; phase < 4; phase++) begin
      set_order(phase[0]);
      steady_send = (phase == 2);
      flush_odds = (phase == 3) ? 90 : 10;
      repeat (30) begin
        if ($urandom_range(0, flush_odds - 1) == 0) flush_store();
        else add_entry(rand_pass(), rand_tex(), rand_colour());
      end
      flush_store();
      wait_idle();
    end
    steady_send = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_sorted_keys();
    test_arrival_order();
    test_full_store();
    test_random();
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

endmodule
